[design/vertex_normal_accumulator_top_macros.svh]
// Assertion macros shared by the vertex normal accumulator RTL.
`ifndef VERTEX_NORMAL_ACCUMULATOR_TOP_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VNA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define VNA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/vna_pkg.sv]
// Shared widths and types of the vertex normal accumulator.
`default_nettype none
package vna_pkg;
    localparam int COORD_W    = 24;
    localparam int SUM_W      = 32;
    localparam int EDGE_SHIFT = (COORD_W > 30) ? COORD_W - 30 : 0;
    localparam int EDGE_W     = COORD_W + 1 - EDGE_SHIFT;
    localparam int CROSS_W    = 2 * EDGE_W + 1;
    localparam int VEC_W      = (CROSS_W > SUM_W) ? CROSS_W : SUM_W;
    localparam int MAG_W      = (VEC_W > 32) ? VEC_W : 32;
    localparam int NRM_W      = 16;
    localparam int IN_DATA_W  = ((9 * COORD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 3 * NRM_W;

    typedef logic signed [VEC_W-1:0] t_vec;

    typedef struct packed {
        logic done;
        logic zero;
    } t_unit_stat;
endpackage
`default_nettype wire

[design/vna_unit.sv]
// Iterative unit that scales a signed 3-vector to a Q1.15 unit vector.
`default_nettype none
module vna_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  vna_pkg::t_vec [2:0]  i_vec,
    output vna_pkg::t_unit_stat  o_stat,
    output logic signed [15:0]   o_q [3]
);
    import vna_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_SQ    = 3'd2;
    localparam logic [2:0] S_SQRT  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        r_neg;
    logic [MAG_W-1:0]  r_m [3];
    logic [2:0]        r_k;
    logic [61:0]       r_prod;
    logic [63:0]       r_s;
    logic [63:0]       r_rad;
    logic [63:0]       r_res;
    logic [63:0]       r_bit;
    logic [4:0]        r_step;
    logic [1:0]        r_ci;
    logic [32:0]       r_rem;
    logic [15:0]       r_nlo;
    logic [15:0]       r_quo;
    logic signed [15:0] r_q [3];
    logic              r_zero;
    logic              r_done;

    logic              w_big;
    logic [30:0]       w_sq_op;
    logic [30:0]       w_div_m;
    logic [63:0]       w_trial;
    logic [31:0]       w_len;
    logic [47:0]       w_num;
    logic [32:0]       w_sh;
    logic [15:0]       w_sat;

    assign w_big = (|r_m[0][MAG_W-1:31]) | (|r_m[1][MAG_W-1:31]) | (|r_m[2][MAG_W-1:31]);

    always_comb begin
        case (r_k)
            3'd0:    w_sq_op = r_m[0][30:0];
            3'd1:    w_sq_op = r_m[1][30:0];
            default: w_sq_op = r_m[2][30:0];
        endcase
        case (r_ci)
            2'd0:    w_div_m = r_m[0][30:0];
            2'd1:    w_div_m = r_m[1][30:0];
            default: w_div_m = r_m[2][30:0];
        endcase
    end

    assign w_trial = r_res + r_bit;
    assign w_len   = r_res[31:0];
    // Rounded numerator m * 2^15 + len / 2.
    assign w_num   = {2'b00, w_div_m, 15'd0} + {17'd0, w_len[31:1]};
    assign w_sh    = {r_rem[31:0], r_nlo[15]};
    assign w_sat   = (r_quo > 16'd32767) ? 16'd32767 : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 3; i++) begin
                            r_neg[i] <= i_vec[i][VEC_W-1];
                            r_m[i]   <= MAG_W'(i_vec[i][VEC_W-1] ?
                                        $unsigned(-i_vec[i]) : $unsigned(i_vec[i]));
                        end
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (w_big) begin
                        for (int i = 0; i < 3; i++) begin
                            r_m[i] <= r_m[i] >> 1;
                        end
                    end else begin
                        r_k     <= 3'd0;
                        r_s     <= 64'd0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_prod <= w_sq_op * w_sq_op;
                    if (r_k != 3'd0) begin
                        r_s <= r_s + {2'b00, r_prod};
                    end
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd4) begin
                        r_rad   <= r_s;
                        r_res   <= 64'd0;
                        r_bit   <= 64'd1 << 62;
                        r_step  <= 5'd0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_rad >= w_trial) begin
                        r_rad <= r_rad - w_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit  <= r_bit >> 2;
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) begin
                        r_ci    <= 2'd0;
                        r_step  <= 5'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_len == 32'd0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_q[i] <= 16'sd0;
                        end
                        r_zero  <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_step == 5'd0) begin
                        // The quotient stays below 2^16, so the top bits already sit below len.
                        r_rem  <= {1'b0, w_num[47:16]};
                        r_nlo  <= w_num[15:0];
                        r_quo  <= 16'd0;
                        r_step <= 5'd1;
                    end else if (r_step != 5'd17) begin
                        if (w_sh >= {1'b0, w_len}) begin
                            r_rem <= w_sh - {1'b0, w_len};
                            r_quo <= {r_quo[14:0], 1'b1};
                        end else begin
                            r_rem <= w_sh;
                            r_quo <= {r_quo[14:0], 1'b0};
                        end
                        r_nlo  <= {r_nlo[14:0], 1'b0};
                        r_step <= r_step + 5'd1;
                    end else begin
                        r_q[r_ci] <= r_neg[r_ci] ? -$signed(w_sat) : $signed(w_sat);
                        r_step    <= 5'd0;
                        r_ci      <= r_ci + 2'd1;
                        if (r_ci == 2'd2) begin
                            r_zero  <= 1'b0;
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.zero = r_zero;
    assign o_q         = r_q;
endmodule
`default_nettype wire

[design/vertex_normal_accumulator_top.sv]
// Top level of the vertex normal accumulator.
// Triangles of one vertex arrive one item at a time; tlast closes the vertex and
// tuser clear marks a vertex without faces. A triangle item keeps tready low through
// the cross product on one multiplier, a start state, the shared scaling unit (range
// shift, squares, square root and division into three 16-bit quotients) and the step
// that takes its result. A degenerate triangle skips the division. A closing item adds
// one more pass of the scaling unit on the sums, plus any wait for the output register.
// Input tready is high only while the block is idle; a finished result waits in the
// output register while the next item is taken.
`default_nettype none
module vertex_normal_accumulator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz from the lowest bit up
    input  logic [vna_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // has_face
    input  logic                            i_s_axis_tuser,
    // last_face
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // normal_x, normal_y, normal_z from the lowest bit up
    output logic [vna_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // zero_normal
    output logic                            o_m_axis_tuser
);
    import vna_pkg::*;

    `include "vertex_normal_accumulator_top_macros.svh"

    localparam logic [2:0] T_IDLE   = 3'd0;
    localparam logic [2:0] T_CROSS  = 3'd1;
    localparam logic [2:0] T_FSTART = 3'd2;
    localparam logic [2:0] T_FUNIT  = 3'd3;
    localparam logic [2:0] T_VSTART = 3'd4;
    localparam logic [2:0] T_VUNIT  = 3'd5;
    localparam logic [2:0] T_VOUT   = 3'd6;

    localparam logic signed [SUM_W:0] SumMax = (SUM_W+1)'((64'sd1 <<< (SUM_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W:0] SumMin = -SumMax - (SUM_W+1)'(1);

    logic [2:0]                 r_state;
    logic signed [COORD_W-1:0]  r_c [9];
    logic                       r_last;
    logic [2:0]                 r_k;
    logic signed [2*EDGE_W-1:0] r_prod;
    logic signed [CROSS_W-1:0]  r_v [3];
    logic signed [SUM_W-1:0]    r_sum [3];
    logic                       r_ovalid;
    logic signed [15:0]         r_n [3];
    logic                       r_nzero;

    logic signed [EDGE_W-1:0]   w_e1 [3];
    logic signed [EDGE_W-1:0]   w_e2 [3];
    logic signed [EDGE_W-1:0]   w_opa;
    logic signed [EDGE_W-1:0]   w_opb;
    logic signed [CROSS_W-1:0]  w_pext;
    logic                       w_start;
    t_vec [2:0]                 w_vec;
    t_unit_stat                 w_stat;
    logic signed [15:0]         w_q [3];
    logic                       w_out_free;

    function automatic logic signed [EDGE_W-1:0] f_edge(
        input logic signed [COORD_W-1:0] p,
        input logic signed [COORD_W-1:0] q
    );
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        m;
        d = {p[COORD_W-1], p} - {q[COORD_W-1], q};
        m = (d[COORD_W] ? $unsigned(-d) : $unsigned(d)) >> EDGE_SHIFT;
        return d[COORD_W] ? -$signed(m[EDGE_W-1:0]) : $signed(m[EDGE_W-1:0]);
    endfunction

    function automatic logic signed [SUM_W-1:0] f_sat_add(
        input logic signed [SUM_W-1:0] s,
        input logic signed [15:0]      v
    );
        logic signed [SUM_W:0] t;
        t = (SUM_W+1)'(s) + (SUM_W+1)'(v);
        if (t > SumMax) begin
            t = SumMax;
        end else if (t < SumMin) begin
            t = SumMin;
        end
        return t[SUM_W-1:0];
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_e1[i] = f_edge(r_c[i], r_c[3+i]);
            w_e2[i] = f_edge(r_c[6+i], r_c[3+i]);
        end
        // Cross product e2 x e1, one partial product per cycle.
        case (r_k)
            3'd0:    begin w_opa = w_e2[1]; w_opb = w_e1[2]; end
            3'd1:    begin w_opa = w_e1[1]; w_opb = w_e2[2]; end
            3'd2:    begin w_opa = w_e2[2]; w_opb = w_e1[0]; end
            3'd3:    begin w_opa = w_e1[2]; w_opb = w_e2[0]; end
            3'd4:    begin w_opa = w_e2[0]; w_opb = w_e1[1]; end
            default: begin w_opa = w_e1[0]; w_opb = w_e2[1]; end
        endcase
        for (int i = 0; i < 3; i++) begin
            w_vec[i] = (r_state == T_FSTART) ? VEC_W'(r_v[i]) : VEC_W'(r_sum[i]);
        end
    end

    assign w_pext     = CROSS_W'(r_prod);
    assign w_start    = (r_state == T_FSTART) || (r_state == T_VSTART);
    assign w_out_free = !r_ovalid || i_m_axis_tready;

    vna_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_vec   (w_vec),
        .o_stat  (w_stat),
        .o_q     (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            if (r_state == T_VOUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                T_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        for (int i = 0; i < 9; i++) begin
                            r_c[i] <= i_s_axis_tdata[i*COORD_W +: COORD_W];
                        end
                        r_last  <= i_s_axis_tlast;
                        r_k     <= 3'd0;
                        r_state <= i_s_axis_tuser ? T_CROSS : T_VSTART;
                    end
                end
                T_CROSS: begin
                    r_prod <= w_opa * w_opb;
                    case (r_k)
                        3'd1:    r_v[0] <= w_pext;
                        3'd2:    r_v[0] <= r_v[0] - w_pext;
                        3'd3:    r_v[1] <= w_pext;
                        3'd4:    r_v[1] <= r_v[1] - w_pext;
                        3'd5:    r_v[2] <= w_pext;
                        3'd6:    r_v[2] <= r_v[2] - w_pext;
                        default: ;
                    endcase
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd6) begin
                        r_state <= T_FSTART;
                    end
                end
                T_FSTART: r_state <= T_FUNIT;
                T_FUNIT: begin
                    if (w_stat.done) begin
                        for (int i = 0; i < 3; i++) begin
                            r_sum[i] <= f_sat_add(r_sum[i], w_q[i]);
                        end
                        r_state <= r_last ? T_VSTART : T_IDLE;
                    end
                end
                T_VSTART: r_state <= T_VUNIT;
                T_VUNIT: begin
                    if (w_stat.done) begin
                        r_state <= T_VOUT;
                    end
                end
                T_VOUT: begin
                    if (w_out_free) begin
                        r_n      <= w_q;
                        r_nzero  <= w_stat.zero;
                        for (int i = 0; i < 3; i++) begin
                            r_sum[i] <= '0;
                        end
                        r_state <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == T_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_n[2], r_n[1], r_n[0]};
    assign o_m_axis_tuser  = r_nzero;

    `VNA_ASSERT_IMP(a_zero_out, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata == '0, "zero normal carries nonzero components")
    `VNA_ASSERT_IMP(a_no_min, o_m_axis_tvalid, o_m_axis_tdata[15:0] != 16'h8000 && o_m_axis_tdata[31:16] != 16'h8000 && o_m_axis_tdata[47:32] != 16'h8000, "normal component at negative full scale")
    `VNA_ASSERT_IMP(a_done_state, w_stat.done, r_state == T_FUNIT || r_state == T_VUNIT, "scaling unit finished while not awaited")
    `VNA_ASSERT_NXT(a_accept_busy, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "block stayed ready after taking an item")
endmodule
`default_nettype wire
